[rtl/core/aabb_cc_pkg.sv]
package aabb_cc_pkg;

	localparam int COORD_W = 32;
	localparam int RAD_W   = COORD_W - 1;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int RSQ_W   = 2 * RAD_W;
	localparam int DSQ_W   = SQ_W + 2;
	localparam int IDX_W   = 3;

	localparam logic [1:0] OP_POINT  = 2'd0;
	localparam logic [1:0] OP_BOX    = 2'd1;
	localparam logic [1:0] OP_SPHERE = 2'd2;

	localparam logic [1:0] RES_DISJOINT  = 2'd0;
	localparam logic [1:0] RES_CONTAINED = 2'd1;
	localparam logic [1:0] RES_INTERSECT = 2'd2;

	localparam logic [IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	typedef struct packed {
		logic [1:0]                 operation;
		logic signed [COORD_W-1:0]  qa_x;
		logic signed [COORD_W-1:0]  qa_y;
		logic signed [COORD_W-1:0]  qa_z;
		logic signed [COORD_W-1:0]  qb_x;
		logic signed [COORD_W-1:0]  qb_y;
		logic signed [COORD_W-1:0]  qb_z;
		logic [RAD_W-1:0]           radius;
	} query_t;

	typedef struct packed {
		logic [1:0] containment;
		logic       overlaps;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	// per-query decisions that ride along the pipeline
	typedef struct packed {
		logic [1:0] op;
		logic       point_dis;
		logic       box_dis;
		logic       box_in;
		logic       sph_in;
	} flags_t;

endpackage

[rtl/core/aabb_cc_front.sv]
module aabb_cc_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    query_valid,
	output logic                                    query_ready,
	input  aabb_cc_pkg::query_t                     query,
	input  aabb_cc_pkg::box_t                       box,
	output logic                                    v_s2,
	input  logic                                    nxt_ready,
	output aabb_cc_pkg::flags_t                     flags_s2,
	output logic signed [aabb_cc_pkg::COORD_W-1:0]  pnt_s2 [3],
	output logic signed [aabb_cc_pkg::COORD_W-1:0]  ctr_s2 [3],
	output logic [aabb_cc_pkg::RAD_W-1:0]           rad_s2
);
	import aabb_cc_pkg::*;

	localparam int EW = COORD_W + 2;

	query_t q_s1;
	logic   v_s1;
	logic   ready_s1;
	logic   ready_s2;

	logic signed [COORD_W-1:0] mn [3];
	logic signed [COORD_W-1:0] mx [3];
	logic signed [COORD_W-1:0] qa [3];
	logic signed [COORD_W-1:0] qb [3];
	logic signed [COORD_W-1:0] hi_c [3];
	logic signed [COORD_W-1:0] pnt [3];
	logic signed [EW-1:0]      rad_e;
	logic [2:0] pt_out, bx_sep, bx_in, sp_in;
	flags_t flags;

	assign ready_s2    = !v_s2 || nxt_ready;
	assign ready_s1    = !v_s1 || ready_s2;
	assign query_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && query_valid) begin
			q_s1 <= query;
		end
	end

	always_comb begin
		mn[0] = box.min_x;  mn[1] = box.min_y;  mn[2] = box.min_z;
		mx[0] = box.max_x;  mx[1] = box.max_y;  mx[2] = box.max_z;
		qa[0] = q_s1.qa_x;  qa[1] = q_s1.qa_y;  qa[2] = q_s1.qa_z;
		qb[0] = q_s1.qb_x;  qb[1] = q_s1.qb_y;  qb[2] = q_s1.qb_z;
		rad_e = $signed({3'b000, q_s1.radius});
		for (int i = 0; i < 3; i++) begin
			hi_c[i]   = (qa[i] > mx[i]) ? mx[i] : qa[i];
			pnt[i]    = (hi_c[i] < mn[i]) ? mn[i] : hi_c[i];
			pt_out[i] = (qa[i] > mx[i]) || (qa[i] < mn[i]);
			bx_sep[i] = (mx[i] < qa[i]) || (mn[i] > qb[i]);
			bx_in[i]  = (mn[i] <= qa[i]) && (mx[i] >= qb[i]);
			sp_in[i]  = ((EW'(qa[i]) + rad_e) <= EW'(mx[i]))
				&& ((EW'(qa[i]) - rad_e) >= EW'(mn[i]));
		end
		flags.op        = q_s1.operation;
		flags.point_dis = |pt_out;
		flags.box_dis   = |bx_sep;
		flags.box_in    = &bx_in;
		flags.sph_in    = &sp_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			flags_s2 <= flags;
			pnt_s2   <= pnt;
			ctr_s2   <= qa;
			rad_s2   <= q_s1.radius;
		end
	end

endmodule

[rtl/core/aabb_cc_square.sv]
module aabb_cc_square (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    v_s2,
	output logic                                    ready_s3,
	input  aabb_cc_pkg::flags_t                     flags_s2,
	input  logic signed [aabb_cc_pkg::COORD_W-1:0]  pnt_s2 [3],
	input  logic signed [aabb_cc_pkg::COORD_W-1:0]  ctr_s2 [3],
	input  logic [aabb_cc_pkg::RAD_W-1:0]           rad_s2,
	output logic                                    v_s4,
	input  logic                                    nxt_ready,
	output aabb_cc_pkg::flags_t                     flags_s4,
	output logic [aabb_cc_pkg::SQ_W-1:0]            sq_s4 [3],
	output logic [aabb_cc_pkg::RSQ_W-1:0]           rsq_s4
);
	import aabb_cc_pkg::*;

	localparam int DW = COORD_W + 1;

	logic                 v_s3;
	logic                 ready_s4;
	flags_t               flags_s3;
	logic [COORD_W-1:0]   dist_s3 [3];
	logic [RAD_W-1:0]     rad_s3;
	logic signed [DW-1:0] diff [3];
	logic [DW-1:0]        mag [3];
	logic [COORD_W-1:0]   gap [3];

	assign ready_s4 = !v_s4 || nxt_ready;
	assign ready_s3 = !v_s3 || ready_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = DW'(pnt_s2[i]) - DW'(ctr_s2[i]);
			mag[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
			gap[i]  = mag[i][COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			flags_s3 <= flags_s2;
			dist_s3  <= gap;
			rad_s3   <= rad_s2;
		end
		if (ready_s4 && v_s3) begin
			flags_s4 <= flags_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(dist_s3[i]) * SQ_W'(dist_s3[i]);
			end
			rsq_s4 <= RSQ_W'(rad_s3) * RSQ_W'(rad_s3);
		end
	end

endmodule

[rtl/core/aabb_cc_back.sv]
module aabb_cc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_s4,
	output logic                           ready_s5,
	input  aabb_cc_pkg::flags_t            flags_s4,
	input  logic [aabb_cc_pkg::SQ_W-1:0]   sq_s4 [3],
	input  logic [aabb_cc_pkg::RSQ_W-1:0]  rsq_s4,
	output logic                           result_valid,
	input  logic                           result_ready,
	output aabb_cc_pkg::result_t           result
);
	import aabb_cc_pkg::*;

	logic               v_s5;
	logic               ready_s6;
	flags_t             flags_s5;
	logic [DSQ_W-1:0]   dsq_s5;
	logic [RSQ_W-1:0]   rsq_s5;
	logic               far;
	logic [1:0]         res;

	assign ready_s6 = !result_valid || result_ready;
	assign ready_s5 = !v_s5 || ready_s6;

	assign far = dsq_s5 > DSQ_W'(rsq_s5);

	always_comb begin
		unique case (flags_s5.op)
			OP_POINT:  res = flags_s5.point_dis ? RES_DISJOINT : RES_CONTAINED;
			OP_BOX:    res = flags_s5.box_dis ? RES_DISJOINT
				: (flags_s5.box_in ? RES_CONTAINED : RES_INTERSECT);
			OP_SPHERE: res = far ? RES_DISJOINT
				: (flags_s5.sph_in ? RES_CONTAINED : RES_INTERSECT);
			default:   res = RES_DISJOINT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (ready_s5) begin
				v_s5 <= v_s4;
			end
			if (ready_s6) begin
				result_valid <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			flags_s5 <= flags_s4;
			dsq_s5   <= DSQ_W'(sq_s4[0]) + DSQ_W'(sq_s4[1]) + DSQ_W'(sq_s4[2]);
			rsq_s5   <= rsq_s4;
		end
		if (ready_s6 && v_s5) begin
			result.containment <= res;
			result.overlaps    <= (res != RES_DISJOINT);
		end
	end

endmodule

[rtl/core/aabb_containment_classifier.sv]
// Classifies each query (point, box or sphere) against the reference box held in
// six config registers, giving disjoint / contained / intersecting plus an
// overlap flag. Six register stages: input, bound compares and sphere clamp,
// clamp distance, squaring, sum of squares, compare and classify into the
// output register. A query is taken every cycle while the output side keeps up;
// an empty stage absorbs a word even while the output is stalled. The config
// port is always ready; write it only when no query is in flight.
module aabb_containment_classifier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 query_valid,
	output logic                                 query_ready,
	input  aabb_cc_pkg::query_t                  query,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output aabb_cc_pkg::result_t                 result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [aabb_cc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [aabb_cc_pkg::COORD_W-1:0]      cfg_data
);
	import aabb_cc_pkg::*;

	box_t box_q;

	logic                       v_s2;
	logic                       ready_s3;
	flags_t                     flags_s2;
	logic signed [COORD_W-1:0]  pnt_s2 [3];
	logic signed [COORD_W-1:0]  ctr_s2 [3];
	logic [RAD_W-1:0]           rad_s2;
	logic                       v_s4;
	logic                       ready_s5;
	flags_t                     flags_s4;
	logic [SQ_W-1:0]            sq_s4 [3];
	logic [RSQ_W-1:0]           rsq_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_q.min_x <= cfg_data;
				REG_BOX_MIN_Y: box_q.min_y <= cfg_data;
				REG_BOX_MIN_Z: box_q.min_z <= cfg_data;
				REG_BOX_MAX_X: box_q.max_x <= cfg_data;
				REG_BOX_MAX_Y: box_q.max_y <= cfg_data;
				REG_BOX_MAX_Z: box_q.max_z <= cfg_data;
				default: ;
			endcase
		end
	end

	aabb_cc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.box         (box_q),
		.v_s2        (v_s2),
		.nxt_ready   (ready_s3),
		.flags_s2    (flags_s2),
		.pnt_s2      (pnt_s2),
		.ctr_s2      (ctr_s2),
		.rad_s2      (rad_s2)
	);

	aabb_cc_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s2      (v_s2),
		.ready_s3  (ready_s3),
		.flags_s2  (flags_s2),
		.pnt_s2    (pnt_s2),
		.ctr_s2    (ctr_s2),
		.rad_s2    (rad_s2),
		.v_s4      (v_s4),
		.nxt_ready (ready_s5),
		.flags_s4  (flags_s4),
		.sq_s4     (sq_s4),
		.rsq_s4    (rsq_s4)
	);

	aabb_cc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s4         (v_s4),
		.ready_s5     (ready_s5),
		.flags_s4     (flags_s4),
		.sq_s4        (sq_s4),
		.rsq_s4       (rsq_s4),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_overlap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.overlaps == (result.containment != RES_DISJOINT)))
		else $error("overlap flag disagrees with containment");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ready_s3) |=> (v_s2 && $stable(flags_s2) && $stable(rad_s2)))
		else $error("stage 2 word changed under stall");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !ready_s5) |=> (v_s4 && $stable(flags_s4) && $stable(rsq_s4)))
		else $error("stage 4 word changed under stall");

endmodule

[dv/aabb_classification_monitor.sv]
`timescale 1ns / 100ps

module aabb_classification_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              query_valid,
	input  logic                              query_ready,
	input  aabb_cc_pkg::query_t               query,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  aabb_cc_pkg::result_t              result,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [aabb_cc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [aabb_cc_pkg::COORD_W-1:0]   cfg_data,
	output int                                verdicts_owed,
	output int                                mismatches
);
	import aabb_cc_pkg::*;

	box_t    ref_box;
	result_t verdict_queue[$];
	result_t want;
	int      owed_count = 0;
	int      mismatch_count = 0;

	assign verdicts_owed = owed_count;
	assign mismatches    = mismatch_count;

	function automatic result_t classify_against_box(query_t q, box_t b);
		longint      lo[3], hi[3], a[3], c[3];
		longint      rad, p, d;
		logic [67:0] dist_sq, rad_sq;
		logic        apart, enclosed;
		int          i;
		result_t     v;
		lo[0] = $signed(b.min_x);
		lo[1] = $signed(b.min_y);
		lo[2] = $signed(b.min_z);
		hi[0] = $signed(b.max_x);
		hi[1] = $signed(b.max_y);
		hi[2] = $signed(b.max_z);
		a[0]  = $signed(q.qa_x);
		a[1]  = $signed(q.qa_y);
		a[2]  = $signed(q.qa_z);
		c[0]  = $signed(q.qb_x);
		c[1]  = $signed(q.qb_y);
		c[2]  = $signed(q.qb_z);
		rad   = longint'(q.radius);
		apart    = 1'b0;
		enclosed = 1'b1;
		dist_sq  = '0;
		rad_sq   = 68'(rad) * 68'(rad);
		case (q.operation)
			OP_POINT: begin
				for (i = 0; i < 3; i++)
					if (a[i] > hi[i] || a[i] < lo[i])
						apart = 1'b1;
				v.containment = apart ? RES_DISJOINT : RES_CONTAINED;
			end
			OP_BOX: begin
				for (i = 0; i < 3; i++) begin
					if (hi[i] < a[i] || lo[i] > c[i])
						apart = 1'b1;
					if (!(lo[i] <= a[i] && hi[i] >= c[i]))
						enclosed = 1'b0;
				end
				v.containment = apart ? RES_DISJOINT :
					(enclosed ? RES_CONTAINED : RES_INTERSECT);
			end
			OP_SPHERE: begin
				for (i = 0; i < 3; i++) begin
					// clamp to max first, then to min
					p = (a[i] > hi[i]) ? hi[i] : a[i];
					p = (p < lo[i]) ? lo[i] : p;
					d = p - a[i];
					if (d < 0)
						d = -d;
					dist_sq = dist_sq + 68'(d) * 68'(d);
					if (!(a[i] + rad <= hi[i] && a[i] - rad >= lo[i]))
						enclosed = 1'b0;
				end
				if (dist_sq > rad_sq)
					v.containment = RES_DISJOINT;
				else
					v.containment = enclosed ? RES_CONTAINED : RES_INTERSECT;
			end
			default: v.containment = RES_DISJOINT;
		endcase
		v.overlaps = (v.containment != RES_DISJOINT);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_box = '0;
			verdict_queue.delete();
			owed_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BOX_MIN_X: ref_box.min_x = cfg_data;
					REG_BOX_MIN_Y: ref_box.min_y = cfg_data;
					REG_BOX_MIN_Z: ref_box.min_z = cfg_data;
					REG_BOX_MAX_X: ref_box.max_x = cfg_data;
					REG_BOX_MAX_Y: ref_box.max_y = cfg_data;
					REG_BOX_MAX_Z: ref_box.max_z = cfg_data;
					default: ;
				endcase
			end
			if (query_valid && query_ready)
				verdict_queue.push_back(classify_against_box(query, ref_box));
			if (result_valid && result_ready) begin
				if (verdict_queue.size() == 0) begin
					$error("result word with no query outstanding: containment %0d, overlaps %0d",
						result.containment, result.overlaps);
					mismatch_count++;
				end else begin
					want = verdict_queue.pop_front();
					if (result.containment !== want.containment) begin
						$error("containment: expected %0d, actual %0d",
							want.containment, result.containment);
						mismatch_count++;
					end
					if (result.overlaps !== want.overlaps) begin
						$error("overlaps: expected %0d, actual %0d",
							want.overlaps, result.overlaps);
						mismatch_count++;
					end
				end
			end
			owed_count <= verdict_queue.size();
		end
	end

endmodule

[dv/aabb_containment_classifier_test.sv]
`timescale 1ns / 100ps

module aabb_containment_classifier_test;
	import aabb_cc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint ONE      = 64'sd65536;
	localparam longint C_MIN    = -64'sd2147483648;
	localparam longint C_MAX    = 64'sd2147483647;
	localparam longint RAD_MAX  = 64'sd2147483647;
	localparam longint BLO      = -10 * ONE;
	localparam longint BHI      = 10 * ONE;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEMS_PER_BOX = 92;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                query_valid = 1'b0;
	logic                query_ready;
	query_t              query = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [COORD_W-1:0]  cfg_data = '0;

	int verdicts_owed;
	int mismatches;
	int cycle_count = 0;
	int sender_idle = 0;
	int receiver_stall = 0;

	aabb_containment_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	aabb_classification_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.query_valid   (query_valid),
		.query_ready   (query_ready),
		.query         (query),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.verdicts_owed (verdicts_owed),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(0, 99) >= receiver_stall);

	function automatic logic [COORD_W-1:0] to_coord(longint v);
		if (v > C_MAX)
			v = C_MAX;
		else if (v < C_MIN)
			v = C_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic longint pick_in(longint lo, longint hi);
		longint      t;
		logic [63:0] span;
		if (hi < lo) begin
			t  = lo;
			lo = hi;
			hi = t;
		end
		span = hi - lo + 1;
		return lo + longint'({$urandom, $urandom} % span);
	endfunction

	// often near the bounds, some inside, some anywhere or at the range extremes
	function automatic longint coord_near(longint lo, longint hi);
		case ($urandom_range(0, 9))
			0, 1:    return longint'($signed($urandom));
			2:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
			3, 4:    return lo + longint'($urandom_range(0, 6)) - 3;
			5, 6:    return hi + longint'($urandom_range(0, 6)) - 3;
			default: return pick_in(lo, hi);
		endcase
	endfunction

	function automatic query_t mk_query(logic [1:0] op, longint ax, longint ay, longint az,
		longint bx, longint by, longint bz, longint rad);
		query_t q;
		q.operation = op;
		q.qa_x = to_coord(ax);
		q.qa_y = to_coord(ay);
		q.qa_z = to_coord(az);
		q.qb_x = to_coord(bx);
		q.qb_y = to_coord(by);
		q.qb_z = to_coord(bz);
		q.radius = (rad > RAD_MAX) ? RAD_MAX[RAD_W-1:0] : (rad < 0) ? '0 : rad[RAD_W-1:0];
		return q;
	endfunction

	function automatic box_t mk_box(longint lx, longint ly, longint lz,
		longint hx, longint hy, longint hz);
		box_t b;
		b.min_x = to_coord(lx);
		b.min_y = to_coord(ly);
		b.min_z = to_coord(lz);
		b.max_x = to_coord(hx);
		b.max_y = to_coord(hy);
		b.max_z = to_coord(hz);
		return b;
	endfunction

	// shape 0: full range, 1: inverted on x, otherwise mixed
	function automatic box_t random_box(int shape);
		longint lo[3], hi[3], centre, half, t;
		int     i;
		for (i = 0; i < 3; i++) begin
			case ((shape == 0) ? 0 : $urandom_range(0, 9))
				0: begin
					lo[i] = C_MIN;
					hi[i] = C_MAX;
				end
				1: begin
					lo[i] = longint'($signed($urandom));
					hi[i] = longint'($signed($urandom));
				end
				2: begin
					lo[i] = pick_in(-ONE * 100, ONE * 100);
					hi[i] = lo[i];
				end
				default: begin
					centre = pick_in(-ONE * 1000, ONE * 1000);
					half   = pick_in(0, ONE * 20);
					lo[i]  = centre - half;
					hi[i]  = centre + half;
				end
			endcase
		end
		if (shape == 1 && lo[0] <= hi[0]) begin
			t     = lo[0];
			lo[0] = hi[0] + 1;
			hi[0] = t;
		end
		return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endfunction

	function automatic query_t random_query(box_t b);
		longint     lo[3], hi[3], a[3], c[3], rad, span;
		int         op_pick, style, i;
		logic [1:0] op;
		lo[0] = $signed(b.min_x);
		lo[1] = $signed(b.min_y);
		lo[2] = $signed(b.min_z);
		hi[0] = $signed(b.max_x);
		hi[1] = $signed(b.max_y);
		hi[2] = $signed(b.max_z);
		style = $urandom_range(0, 2);
		for (i = 0; i < 3; i++) begin
			if (style == 0) begin
				a[i] = pick_in(lo[i], hi[i]);
				c[i] = pick_in(a[i], hi[i]);
			end else begin
				a[i] = coord_near(lo[i], hi[i]);
				c[i] = coord_near(lo[i], hi[i]);
			end
		end
		span = hi[0] - lo[0];
		if (span < 0)
			span = -span;
		case ($urandom_range(0, 5))
			0:       rad = 0;
			1:       rad = RAD_MAX;
			2:       rad = longint'($urandom >> 1);
			3:       rad = pick_in(0, 16);
			default: rad = pick_in(0, span / 2 + ONE);
		endcase
		op_pick = $urandom_range(0, 30);
		if (op_pick == 0)
			op = OP_UNUSED;
		else begin
			case (op_pick % 3)
				0:       op = OP_POINT;
				1:       op = OP_BOX;
				default: op = OP_SPHERE;
			endcase
		end
		return mk_query(op, a[0], a[1], a[2], c[0], c[1], c[2], rad);
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_box(box_t b);
		write_reg(REG_BOX_MIN_X, b.min_x);
		write_reg(REG_BOX_MIN_Y, b.min_y);
		write_reg(REG_BOX_MIN_Z, b.min_z);
		write_reg(REG_BOX_MAX_X, b.max_x);
		write_reg(REG_BOX_MAX_Y, b.max_y);
		write_reg(REG_BOX_MAX_Z, b.max_z);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_query(query_t q);
		while ($urandom_range(0, 99) < sender_idle) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query       <= q;
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
	endtask

	task automatic drain;
		query_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		box_t ref_box;
		int   mode, k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle    = 33;
		receiver_stall = 78;
		load_box(mk_box(BLO, BLO, BLO, BHI, BHI, BHI));

		// points
		send_query(mk_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, BLO, BLO, BLO, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, BHI, BHI, BHI, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, BHI + 1, 0, 0, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, 0, 0, BLO - 1, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, 0, C_MAX, 0, 0, 0, 0, 0));
		send_query(mk_query(OP_POINT, ONE, -ONE, ONE, -1, -1, -1, RAD_MAX));
		// boxes
		send_query(mk_query(OP_BOX, BLO, BLO, BLO, BHI, BHI, BHI, 0));
		send_query(mk_query(OP_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
		send_query(mk_query(OP_BOX, -20 * ONE, -20 * ONE, -20 * ONE, 0, 0, 0, 0));
		send_query(mk_query(OP_BOX, BHI + 1, 0, 0, C_MAX, ONE, ONE, 0));
		send_query(mk_query(OP_BOX, C_MIN, -ONE, C_MIN, ONE, ONE, BLO - 1, 0));
		send_query(mk_query(OP_BOX, 5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE,
			-5 * ONE, 0));
		send_query(mk_query(OP_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, RAD_MAX));
		// spheres
		send_query(mk_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 5 * ONE));
		send_query(mk_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, BHI));
		send_query(mk_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, BHI + 1));
		send_query(mk_query(OP_SPHERE, BHI + 3 * ONE, 0, 0, 0, 0, 0, 3 * ONE));
		send_query(mk_query(OP_SPHERE, BHI + 3 * ONE, 0, 0, 0, 0, 0, 3 * ONE - 1));
		send_query(mk_query(OP_SPHERE, BHI + 2 * ONE, BHI + 2 * ONE, BHI + 2 * ONE,
			0, 0, 0, 3 * ONE));
		send_query(mk_query(OP_SPHERE, 0, 0, 0, -1, -1, -1, 0));
		send_query(mk_query(OP_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, RAD_MAX));
		send_query(mk_query(OP_SPHERE, C_MAX, 0, 0, 0, 0, 0, RAD_MAX));
		// unused operation code
		send_query(mk_query(OP_UNUSED, 0, 0, 0, C_MAX, C_MIN, -1, RAD_MAX));
		drain();

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					sender_idle    = 33;
					receiver_stall = 78;
				end
				1: begin
					sender_idle    = 78;
					receiver_stall = 33;
				end
				default: begin
					sender_idle    = 0;
					receiver_stall = 0;
				end
			endcase
			for (k = 0; k < 4; k++) begin
				ref_box = random_box(k);
				load_box(ref_box);
				repeat (ITEMS_PER_BOX)
					send_query(random_query(ref_box));
				drain();
			end
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
